FILE: rtl/vnsw_pkg.sv
// ----------------------------------------------------------------------------
// vnsw_pkg: shared types and elaboration helpers for the shell walker
// Holds the register map, the configuration bundle, the offset entry type and
// the constant functions that build the offset table and shell start table.
// ----------------------------------------------------------------------------
`default_nettype none

package vnsw_pkg;

  localparam int MODE_W  = 2;
  localparam int DIM_W   = 13;
  localparam int SHELL_W = 6;
  // Signed offset width; covers +/-5, the widest reach in the parameter range.
  localparam int OFF_W   = 4;
  localparam int APB_AW  = 4;
  localparam int APB_DW  = 32;

  localparam int DEF_MAX_CHEB_SIZE = 2;
  localparam int DEF_MAX_RADIUS    = 3;
  localparam int DEF_COORD_BITS    = 12;

  localparam logic OP_BEGIN = 1'b0;
  localparam logic OP_NEXT  = 1'b1;

  typedef enum logic [MODE_W-1:0] {
    MODE_CUBE   = 2'd0,
    MODE_SQUARE = 2'd1,
    MODE_SPHERE = 2'd2,
    MODE_CIRCLE = 2'd3
  } shape_t;

  typedef enum logic [1:0] {
    REG_SHAPE_MODE  = 2'd0,
    REG_DIM_COLUMNS = 2'd1,
    REG_DIM_ROWS    = 2'd2,
    REG_DIM_SLICES  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    shape_t             shape_mode;
    logic [DIM_W-1:0]   dim_columns;
    logic [DIM_W-1:0]   dim_rows;
    logic [DIM_W-1:0]   dim_slices;
  } cfg_t;

  typedef struct packed {
    logic signed [OFF_W-1:0] s;
    logic signed [OFF_W-1:0] r;
    logic signed [OFF_W-1:0] c;
  } offset_t;

  // Reach of the offsets in a mode: radius for the round shapes, else cube size.
  function automatic int reach(int cheb, int rad, int mode);
    return (mode >= 2) ? rad : cheb;
  endfunction

  function automatic int slice_reach(int cheb, int rad, int mode);
    return (mode == 0 || mode == 2) ? reach(cheb, rad, mode) : 0;
  endfunction

  function automatic int shell_count(int cheb, int rad, int mode);
    return (mode >= 2) ? rad * rad + 1 : cheb + 1;
  endfunction

  function automatic int abs_int(int v);
    return (v < 0) ? -v : v;
  endfunction

  // Squared radius for the round shapes, largest axis distance otherwise.
  function automatic int dist_of(int mode, int s, int r, int c);
    int m;
    if (mode >= 2) return s * s + r * r + c * c;
    m = abs_int(s);
    if (abs_int(r) > m) m = abs_int(r);
    if (abs_int(c) > m) m = abs_int(c);
    return m;
  endfunction

  function automatic int count_below(int cheb, int rad, int mode, int lim);
    int k;
    int ks;
    int cnt;
    k   = reach(cheb, rad, mode);
    ks  = slice_reach(cheb, rad, mode);
    cnt = 0;
    for (int s = -ks; s <= ks; s++)
      for (int r = -k; r <= k; r++)
        for (int c = -k; c <= k; c++)
          if (dist_of(mode, s, r, c) < lim) cnt++;
    return cnt;
  endfunction

  // Index of the first table entry of shell d in a mode; past the last shell
  // it gives the end of that mode's entries.
  function automatic int shell_first(int cheb, int rad, int mode, int d);
    int base;
    int nsh;
    int lim;
    base = 0;
    for (int m = 0; m < mode; m++)
      base += count_below(cheb, rad, m, shell_count(cheb, rad, m));
    nsh = shell_count(cheb, rad, mode);
    lim = (d < nsh) ? d : nsh;
    return base + count_below(cheb, rad, mode, lim);
  endfunction

  function automatic int table_len(int cheb, int rad);
    return shell_first(cheb, rad, 3, shell_count(cheb, rad, 3));
  endfunction

  function automatic int max_shell(int cheb, int rad);
    int best;
    int n;
    best = 1;
    for (int m = 0; m < 4; m++)
      for (int d = 0; d < shell_count(cheb, rad, m); d++) begin
        n = shell_first(cheb, rad, m, d + 1) - shell_first(cheb, rad, m, d);
        if (n > best) best = n;
      end
    return best;
  endfunction

  // Entry idx of the offset table: modes in order, shells in order, and within
  // a shell slice, row and column descending.
  function automatic offset_t offset_entry(int cheb, int rad, int idx);
    offset_t e;
    int n;
    int k;
    int ks;
    e = '0;
    n = 0;
    for (int m = 0; m < 4; m++) begin
      k  = reach(cheb, rad, m);
      ks = slice_reach(cheb, rad, m);
      for (int d = 0; d < shell_count(cheb, rad, m); d++)
        for (int s = ks; s >= -ks; s--)
          for (int r = k; r >= -k; r--)
            for (int c = k; c >= -k; c--)
              if (dist_of(m, s, r, c) == d) begin
                if (n == idx) begin
                  e.s = OFF_W'(s);
                  e.r = OFF_W'(r);
                  e.c = OFF_W'(c);
                  return e;
                end
                n++;
              end
    end
    return e;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/vnsw_cfg_regs.sv
// ----------------------------------------------------------------------------
// vnsw_cfg_regs: APB register file
// Shape mode and volume dimensions, written on the APB access phase and read
// back combinationally.
// ----------------------------------------------------------------------------
`default_nettype none

module vnsw_cfg_regs (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [vnsw_pkg::APB_AW-1:0]     paddr,
  input  wire logic [vnsw_pkg::APB_DW-1:0]     pwdata,
  output logic      [vnsw_pkg::APB_DW-1:0]     prdata,
  output logic                                 pready,
  output vnsw_pkg::cfg_t                       cfg
);

  localparam int MODE_W = vnsw_pkg::MODE_W;
  localparam int DIM_W  = vnsw_pkg::DIM_W;
  localparam int DW     = vnsw_pkg::APB_DW;

  vnsw_pkg::reg_idx_t reg_sel;
  logic               wr_en;

  assign pready  = 1'b1;
  assign reg_sel = vnsw_pkg::reg_idx_t'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (reg_sel)
        vnsw_pkg::REG_SHAPE_MODE:  cfg.shape_mode  <= vnsw_pkg::shape_t'(pwdata[MODE_W-1:0]);
        vnsw_pkg::REG_DIM_COLUMNS: cfg.dim_columns <= pwdata[DIM_W-1:0];
        vnsw_pkg::REG_DIM_ROWS:    cfg.dim_rows    <= pwdata[DIM_W-1:0];
        vnsw_pkg::REG_DIM_SLICES:  cfg.dim_slices  <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      vnsw_pkg::REG_SHAPE_MODE:  prdata = DW'(cfg.shape_mode);
      vnsw_pkg::REG_DIM_COLUMNS: prdata = DW'(cfg.dim_columns);
      vnsw_pkg::REG_DIM_ROWS:    prdata = DW'(cfg.dim_rows);
      vnsw_pkg::REG_DIM_SLICES:  prdata = DW'(cfg.dim_slices);
      default:                   prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/vnsw_shell_lookup.sv
// ----------------------------------------------------------------------------
// vnsw_shell_lookup: shell start table
// Gives the first table entry and the entry count of the current shell, and
// whether the shell pointer still lies inside the mode's shells.
// ----------------------------------------------------------------------------
`default_nettype none

module vnsw_shell_lookup #(
  parameter int MAX_CHEB_SIZE = vnsw_pkg::DEF_MAX_CHEB_SIZE,
  parameter int MAX_RADIUS    = vnsw_pkg::DEF_MAX_RADIUS,
  parameter int FIRST_W       = 9,
  parameter int POS_W         = 7
) (
  input  wire vnsw_pkg::shape_t               mode,
  input  wire logic [vnsw_pkg::SHELL_W-1:0]   sp,
  output logic                                live,
  output logic      [FIRST_W-1:0]             first,
  output logic      [POS_W-1:0]               size
);

  localparam int SH_W    = vnsw_pkg::SHELL_W;
  localparam int NSH_MAX = (MAX_RADIUS * MAX_RADIUS > MAX_CHEB_SIZE) ?
                           MAX_RADIUS * MAX_RADIUS + 1 : MAX_CHEB_SIZE + 1;
  localparam int SF_W     = $clog2(NSH_MAX + 1);
  localparam int SF_DEPTH = 2 ** SF_W;
  localparam logic [SH_W-1:0] NSH_CHEB  = SH_W'(MAX_CHEB_SIZE + 1);
  localparam logic [SH_W-1:0] NSH_ROUND = SH_W'(MAX_RADIUS * MAX_RADIUS + 1);

  logic [FIRST_W-1:0] start_tab [4 * SF_DEPTH];
  logic [SF_W-1:0]    sp_lo;
  logic [SF_W-1:0]    sp_hi;
  logic [FIRST_W-1:0] last;
  logic [SH_W-1:0]    nsh;

  for (genvar m = 0; m < 4; m++) begin : g_mode
    for (genvar j = 0; j < SF_DEPTH; j++) begin : g_shell
      localparam int START = vnsw_pkg::shell_first(MAX_CHEB_SIZE, MAX_RADIUS, m, j);
      assign start_tab[m * SF_DEPTH + j] = FIRST_W'(START);
    end
  end

  assign nsh   = (mode == vnsw_pkg::MODE_SPHERE || mode == vnsw_pkg::MODE_CIRCLE) ?
                 NSH_ROUND : NSH_CHEB;
  assign live  = sp < nsh;
  assign sp_lo = sp[SF_W-1:0];
  assign sp_hi = sp_lo + 1'b1;
  assign first = start_tab[{mode, sp_lo}];
  assign last  = start_tab[{mode, sp_hi}];
  assign size  = POS_W'(last - first);

endmodule

`default_nettype wire

FILE: rtl/vnsw_offset_rom.sv
// ----------------------------------------------------------------------------
// vnsw_offset_rom: neighbour offset table
// Constant table of slice, row and column offsets for all four modes, read
// through a registered port.
// ----------------------------------------------------------------------------
`default_nettype none

module vnsw_offset_rom #(
  parameter int MAX_CHEB_SIZE = vnsw_pkg::DEF_MAX_CHEB_SIZE,
  parameter int MAX_RADIUS    = vnsw_pkg::DEF_MAX_RADIUS,
  parameter int TABLE_LEN     = 302,
  parameter int ADDR_W        = 9
) (
  input  wire logic                 clk,
  input  wire logic                 rd_en,
  input  wire logic [ADDR_W-1:0]    rd_addr,
  output vnsw_pkg::offset_t         rd_data
);

  vnsw_pkg::offset_t rom [TABLE_LEN];

  for (genvar i = 0; i < TABLE_LEN; i++) begin : g_rom
    localparam vnsw_pkg::offset_t ENTRY =
      vnsw_pkg::offset_entry(MAX_CHEB_SIZE, MAX_RADIUS, i);
    assign rom[i] = ENTRY;
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= rom[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/vnsw_bound_unit.sv
// ----------------------------------------------------------------------------
// vnsw_bound_unit: offset adder and volume check
// Adds one offset triple to the centre and tests every axis against the
// volume; the slice axis is only tested in 3-D modes and reads 0 in 2-D.
// ----------------------------------------------------------------------------
`default_nettype none

module vnsw_bound_unit #(
  parameter int COORD_BITS = vnsw_pkg::DEF_COORD_BITS
) (
  input  wire logic [COORD_BITS-1:0]       centre_s,
  input  wire logic [COORD_BITS-1:0]       centre_r,
  input  wire logic [COORD_BITS-1:0]       centre_c,
  input  wire vnsw_pkg::offset_t           off,
  input  wire vnsw_pkg::cfg_t              cfg,
  input  wire logic                        is3d,
  output logic                             ok,
  output logic      [COORD_BITS-1:0]       pos_s,
  output logic      [COORD_BITS-1:0]       pos_r,
  output logic      [COORD_BITS-1:0]       pos_c
);

  localparam int DIM_W = vnsw_pkg::DIM_W;
  localparam int SW    = ((COORD_BITS > DIM_W) ? COORD_BITS : DIM_W) + 2;

  logic signed [SW-1:0] sum_s;
  logic signed [SW-1:0] sum_r;
  logic signed [SW-1:0] sum_c;
  logic                 ok_s;
  logic                 ok_r;
  logic                 ok_c;

  assign sum_s = $signed({{(SW - COORD_BITS){1'b0}}, centre_s}) + SW'(off.s);
  assign sum_r = $signed({{(SW - COORD_BITS){1'b0}}, centre_r}) + SW'(off.r);
  assign sum_c = $signed({{(SW - COORD_BITS){1'b0}}, centre_c}) + SW'(off.c);

  assign ok_s = !is3d ||
                (!sum_s[SW-1] && sum_s < $signed({{(SW - DIM_W){1'b0}}, cfg.dim_slices}));
  assign ok_r = !sum_r[SW-1] && sum_r < $signed({{(SW - DIM_W){1'b0}}, cfg.dim_rows});
  assign ok_c = !sum_c[SW-1] && sum_c < $signed({{(SW - DIM_W){1'b0}}, cfg.dim_columns});

  assign ok    = ok_s && ok_r && ok_c;
  assign pos_s = is3d ? sum_s[COORD_BITS-1:0] : '0;
  assign pos_r = sum_r[COORD_BITS-1:0];
  assign pos_c = sum_c[COORD_BITS-1:0];

endmodule

`default_nettype wire

FILE: rtl/voxel_neighborhood_shell_walker.sv
// ----------------------------------------------------------------------------
// voxel_neighborhood_shell_walker: shell-by-shell voxel neighbour walker
// A begin transfer stores a centre and a first shell; each next transfer
// returns the following in-volume neighbour up to a last shell, or reports
// that the walk is exhausted.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Handshake                Payload
// s_*      in   s_tvalid / s_tready      tuser: opcode; tdata: centre, shell
// m_*      out  m_tvalid / m_tready      tuser: found; tdata: neighbour voxel
// APB      in   psel, penable, pready    shape mode and volume dimensions
//
// A begin transfer is absorbed in IDLE and produces no result. A next
// transfer is accepted in IDLE; then every table entry it tries takes a SCAN
// step (shell lookup and offset read) and a CHECK step (the add and volume
// check), each empty shell or leftover position stepped over takes a SCAN
// step, SCAN finds the walk exhausted when no neighbour is left, and EMIT
// loads the output register. The registered table read puts CHECK after SCAN.
// Reset clears the walk state and output valid; the tables are constant and
// need no clearing. A stalled output only holds the block in its last step.
// ----------------------------------------------------------------------------
`default_nettype none

module voxel_neighborhood_shell_walker #(
  parameter int MAX_CHEB_SIZE = vnsw_pkg::DEF_MAX_CHEB_SIZE,
  parameter int MAX_RADIUS    = vnsw_pkg::DEF_MAX_RADIUS,
  parameter int COORD_BITS    = vnsw_pkg::DEF_COORD_BITS,
  localparam int IN_DW  = ((3 * COORD_BITS + vnsw_pkg::SHELL_W + 7) / 8) * 8,
  localparam int OUT_DW = ((3 * COORD_BITS + 7) / 8) * 8
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // APB configuration port
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [vnsw_pkg::APB_AW-1:0]     paddr,
  input  wire logic [vnsw_pkg::APB_DW-1:0]     pwdata,
  output logic      [vnsw_pkg::APB_DW-1:0]     prdata,
  output logic                                 pready,
  // Command stream
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [IN_DW-1:0]                s_tdata,  // center_slice, center_row,
                                                          // center_col, shell_limit
  input  wire logic [0:0]                      s_tuser,  // opcode
  // Result stream
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic      [OUT_DW-1:0]               m_tdata,  // out_slice, out_row, out_col
  output logic      [0:0]                      m_tuser   // found
);

  localparam int SH_W      = vnsw_pkg::SHELL_W;
  localparam int TABLE_LEN = vnsw_pkg::table_len(MAX_CHEB_SIZE, MAX_RADIUS);
  localparam int ADDR_W    = $clog2(TABLE_LEN);
  localparam int FIRST_W   = $clog2(TABLE_LEN + 1);
  localparam int POS_W     = $clog2(vnsw_pkg::max_shell(MAX_CHEB_SIZE, MAX_RADIUS) + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CHECK,
    ST_EMIT
  } state_t;

  state_t                 state;
  vnsw_pkg::cfg_t         cfg;

  // Walk state: stored centre, shell pointer and position inside the shell.
  logic [COORD_BITS-1:0]  centre_s;
  logic [COORD_BITS-1:0]  centre_r;
  logic [COORD_BITS-1:0]  centre_c;
  logic [SH_W-1:0]        sp;
  logic [POS_W-1:0]       pos;
  logic [SH_W-1:0]        limit;

  // Pending result.
  logic                   res_found;
  logic [COORD_BITS-1:0]  res_s;
  logic [COORD_BITS-1:0]  res_r;
  logic [COORD_BITS-1:0]  res_c;

  // Unpacked command fields.
  logic                   in_opcode;
  logic [COORD_BITS-1:0]  in_slice;
  logic [COORD_BITS-1:0]  in_row;
  logic [COORD_BITS-1:0]  in_col;
  logic [SH_W-1:0]        in_limit;

  logic                   is3d;
  logic                   sh_live;
  logic [FIRST_W-1:0]     sh_first;
  logic [POS_W-1:0]       sh_size;
  logic                   walk_live;
  logic                   pos_past;
  logic [POS_W-1:0]       pos_inc;
  logic                   rom_rd_en;
  logic [ADDR_W-1:0]      rom_addr;
  vnsw_pkg::offset_t      rom_data;
  logic                   bnd_ok;
  logic [COORD_BITS-1:0]  bnd_s;
  logic [COORD_BITS-1:0]  bnd_r;
  logic [COORD_BITS-1:0]  bnd_c;

  assign in_opcode = s_tuser[0];
  assign in_slice  = s_tdata[COORD_BITS-1:0];
  assign in_row    = s_tdata[2*COORD_BITS-1:COORD_BITS];
  assign in_col    = s_tdata[3*COORD_BITS-1:2*COORD_BITS];
  assign in_limit  = s_tdata[3*COORD_BITS+SH_W-1:3*COORD_BITS];

  assign is3d = (cfg.shape_mode == vnsw_pkg::MODE_CUBE) ||
                (cfg.shape_mode == vnsw_pkg::MODE_SPHERE);

  // The block takes a command only between walks.
  assign s_tready = (state == ST_IDLE);

  vnsw_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  vnsw_shell_lookup #(
    .MAX_CHEB_SIZE (MAX_CHEB_SIZE),
    .MAX_RADIUS    (MAX_RADIUS),
    .FIRST_W       (FIRST_W),
    .POS_W         (POS_W)
  ) u_shell (
    .mode  (cfg.shape_mode),
    .sp    (sp),
    .live  (sh_live),
    .first (sh_first),
    .size  (sh_size)
  );

  // The walk continues while the pointer is inside the mode's shells and not
  // past the requested last shell. A position at or beyond the shell's size
  // (left over from a different mode) just moves on to the next shell.
  assign walk_live = sh_live && (sp <= limit);
  assign pos_past  = pos >= sh_size;
  assign pos_inc   = pos + 1'b1;
  assign rom_rd_en = (state == ST_SCAN) && walk_live && !pos_past;
  assign rom_addr  = ADDR_W'(sh_first) + ADDR_W'(pos);

  vnsw_offset_rom #(
    .MAX_CHEB_SIZE (MAX_CHEB_SIZE),
    .MAX_RADIUS    (MAX_RADIUS),
    .TABLE_LEN     (TABLE_LEN),
    .ADDR_W        (ADDR_W)
  ) u_rom (
    .clk     (clk),
    .rd_en   (rom_rd_en),
    .rd_addr (rom_addr),
    .rd_data (rom_data)
  );

  vnsw_bound_unit #(
    .COORD_BITS (COORD_BITS)
  ) u_bound (
    .centre_s (centre_s),
    .centre_r (centre_r),
    .centre_c (centre_c),
    .off      (rom_data),
    .cfg      (cfg),
    .is3d     (is3d),
    .ok       (bnd_ok),
    .pos_s    (bnd_s),
    .pos_r    (bnd_r),
    .pos_c    (bnd_c)
  );

  // Sequencer. SCAN resolves the shell and issues the offset read, CHECK adds
  // the offset and tests the volume, EMIT waits for a free output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      centre_s <= '0;
      centre_r <= '0;
      centre_c <= '0;
      sp       <= '0;
      pos      <= '0;
      limit    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // In EMIT the output register is reloaded below instead.
      if (m_tvalid && m_tready && state != ST_EMIT) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            if (in_opcode == vnsw_pkg::OP_BEGIN) begin
              // In 2-D modes the slice is pinned to zero.
              centre_s <= is3d ? in_slice : '0;
              centre_r <= in_row;
              centre_c <= in_col;
              sp       <= in_limit;
              pos      <= '0;
            end else begin
              limit <= in_limit;
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (!walk_live) begin
            res_found <= 1'b0;
            res_s     <= '0;
            res_r     <= '0;
            res_c     <= '0;
            state     <= ST_EMIT;
          end else if (pos_past) begin
            pos <= '0;
            sp  <= sp + 1'b1;
          end else begin
            if (pos_inc == sh_size) begin
              pos <= '0;
              sp  <= sp + 1'b1;
            end else begin
              pos <= pos_inc;
            end
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (bnd_ok) begin
            res_found <= 1'b1;
            res_s     <= bnd_s;
            res_r     <= bnd_r;
            res_c     <= bnd_c;
            state     <= ST_EMIT;
          end else begin
            state <= ST_SCAN;
          end
        end
        ST_EMIT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= OUT_DW'({res_c, res_r, res_s});
            m_tuser  <= res_found;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  // The volume check always consumes an offset read issued the cycle before.
  a_check_after_scan: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CHECK) |-> ($past(state) == ST_SCAN))
    else $error("volume check without a preceding offset read");

  // Offset reads stay inside the table.
  a_rom_addr_range: assert property (@(posedge clk) disable iff (rst)
    rom_rd_en |-> ({1'b0, rom_addr} < (ADDR_W + 1)'(TABLE_LEN)))
    else $error("offset read beyond the table");

  // Running out of shells always yields a not-found result.
  a_exhaust_result: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_SCAN) && !walk_live) |=> ((state == ST_EMIT) && !res_found))
    else $error("exhausted walk did not produce a not-found result");

  // A not-found result carries all-zero coordinates.
  a_notfound_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
    else $error("not-found result with nonzero coordinates");
`endif

endmodule

`default_nettype wire
